FILE: design/lcme_pkg.sv
// ----------------------------------------------------------------------------
// lcme_pkg: shared types and constants of the latency cost model evaluator
// Widths of the datapath, configuration codes, status codes and the structs
// handed from cell to cell along the chain.
// ----------------------------------------------------------------------------
package lcme_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int COEFF_W     = 32;
  // multiplicand of the model terms (d^2, d*P)
  localparam int M_W   = 2 * LENGTH_BITS;
  localparam int P_W   = COEFF_W + M_W;
  localparam int SUM_W = P_W + 4;
  // linear root coefficient b and constant magnitude |c|
  localparam int B_W   = COEFF_W + LENGTH_BITS;
  localparam int HI_W  = B_W - COEFF_W;
  localparam int R_W   = B_W + 1;
  localparam int D_W   = 2 * R_W;
  localparam int A2_W  = COEFF_W + 1;

  localparam logic [COEFF_W-1:0]     TIME_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFILL_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_PROFILE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_CONSTANT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_ONE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_TWO      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_THREE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_FOUR     = 3'd6;

  localparam logic KIND_PREDICT = 1'b0;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_ROOT     = 3'd1,
    ST_NEG_ROOT    = 3'd2,
    ST_NOT_PREFILL = 3'd3,
    ST_ZERO_LEAD   = 3'd4
  } status_t;

  typedef struct packed {
    logic               prefill_mode;
    logic               prefix_profile;
    logic [COEFF_W-1:0] coeff_constant;
    logic [COEFF_W-1:0] coeff_one;
    logic [COEFF_W-1:0] coeff_two;
    logic [COEFF_W-1:0] coeff_three;
    logic [COEFF_W-1:0] coeff_four;
  } cfg_t;

  typedef struct packed {
    logic                   vld;
    logic                   kind;
    logic [COEFF_W-1:0]     ptime;
    logic [LENGTH_BITS-1:0] pre;
    status_t                status;
  } tag_t;

  typedef struct packed {
    tag_t            tag;
    logic [D_W-1:0]  d;
    logic [R_W:0]    rem;
    logic [R_W-1:0]  root;
    logic [B_W-1:0]  b;
    logic [A2_W-1:0] a2;
  } sq_t;

  typedef struct packed {
    tag_t            tag;
    logic [R_W-1:0]  num;
    logic [A2_W-1:0] rem;
    logic [R_W-1:0]  q;
    logic [A2_W-1:0] dv;
  } dv_t;

  typedef struct packed {
    logic [COEFF_W-1:0]     ptime;
    logic [LENGTH_BITS-1:0] limit;
    status_t                status;
  } result_t;

endpackage

FILE: design/lcme_front.sv
// ----------------------------------------------------------------------------
// lcme_front: model terms, root coefficients and discriminant
// Five register stages: capture, term selection, products, prediction sum and
// square partials, square sums; status and discriminant then go into the root chain.
// ----------------------------------------------------------------------------
module lcme_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic                            in_kind,
  input  logic [lcme_pkg::LENGTH_BITS-1:0] in_token_length,
  input  logic [lcme_pkg::LENGTH_BITS-1:0] in_prefix_tokens,
  input  logic                            in_add_constant,
  input  logic [lcme_pkg::COEFF_W-1:0]    in_time_budget,
  input  lcme_pkg::cfg_t                  cfg,
  output lcme_pkg::sq_t                   sq_o
);
  import lcme_pkg::*;

  // stage 1: captured transaction
  logic                   s1_vld_r, s1_kind_r, s1_addc_r;
  logic [LENGTH_BITS-1:0] s1_len_r, s1_pre_r;
  logic [COEFF_W-1:0]     s1_t_r;

  // stage 2
  logic                   s2_vld_r, s2_kind_r, s2_addc_r, s2_usecp_r;
  logic [LENGTH_BITS-1:0] s2_pre_r;
  logic [COEFF_W-1:0]     s2_t_r;
  logic [M_W-1:0]         s2_m1_r, s2_m2_r, s2_m3_r;
  logic                   s2_n1_r, s2_n2_r, s2_n3_r;
  logic [B_W-1:0]         s2_cp_r, s2_c3p_r;

  // stage 3
  logic                   s3_vld_r, s3_kind_r, s3_addc_r, s3_cpos_r;
  logic [LENGTH_BITS-1:0] s3_pre_r;
  logic [P_W-1:0]         s3_p1_r, s3_p2_r, s3_p3_r;
  logic                   s3_n1_r, s3_n2_r, s3_n3_r;
  logic [B_W-1:0]         s3_cpt_r, s3_b_r, s3_cmag_r;
  logic [COEFF_W-1:0]     s3_a_r;

  // stage 4
  logic                     s4_vld_r, s4_kind_r, s4_cpos_r;
  logic [LENGTH_BITS-1:0]   s4_pre_r;
  logic [COEFF_W-1:0]       s4_ptime_r, s4_a_r;
  logic [B_W-1:0]           s4_b_r;
  logic [2*COEFF_W-1:0]     s4_bll_r, s4_acl_r;
  logic [COEFF_W+HI_W-1:0]  s4_blh_r, s4_ach_r;
  logic [2*HI_W-1:0]        s4_bhh_r;

  // stage 5
  logic                   s5_vld_r, s5_kind_r, s5_cpos_r;
  logic [LENGTH_BITS-1:0] s5_pre_r;
  logic [COEFF_W-1:0]     s5_ptime_r, s5_a_r;
  logic [B_W-1:0]         s5_b_r;
  logic [D_W-1:0]         s5_bsq_r, s5_fac_r;

  // stage 1 -> 2
  logic                   dneg;
  logic [LENGTH_BITS-1:0] dmag;
  logic [M_W-1:0]         dsq_nxt, dp_nxt, m1_nxt, m2_nxt, m3_nxt;
  logic                   n1_nxt, n2_nxt, n3_nxt, usecp_nxt;
  logic [B_W-1:0]         cp_nxt, c3p_nxt;

  always_comb begin
    dneg    = s1_len_r < s1_pre_r;
    dmag    = dneg ? (s1_pre_r - s1_len_r) : (s1_len_r - s1_pre_r);
    dsq_nxt = M_W'(dmag) * M_W'(dmag);
    dp_nxt  = M_W'(dmag) * M_W'(s1_pre_r);
    cp_nxt  = B_W'(cfg.coeff_four) * B_W'(s1_pre_r);
    c3p_nxt = B_W'(cfg.coeff_three) * B_W'(s1_pre_r);
    m3_nxt    = '0;
    n3_nxt    = 1'b0;
    usecp_nxt = 1'b0;
    if (cfg.prefill_mode && !cfg.prefix_profile) begin
      m1_nxt = M_W'(dmag);
      n1_nxt = dneg;
      m2_nxt = dsq_nxt;
      n2_nxt = 1'b0;
    end else if (cfg.prefill_mode) begin
      m1_nxt    = dsq_nxt;
      n1_nxt    = 1'b0;
      m2_nxt    = M_W'(dmag);
      n2_nxt    = dneg;
      m3_nxt    = dp_nxt;
      n3_nxt    = dneg;
      usecp_nxt = 1'b1;
    end else begin
      // decode: c1 + c2*(L-1), with L of zero giving minus c2
      m1_nxt = M_W'(1);
      n1_nxt = 1'b0;
      n2_nxt = (s1_len_r == '0);
      m2_nxt = n2_nxt ? M_W'(1) : (M_W'(s1_len_r) - M_W'(1));
    end
  end

  // stage 2 -> 3
  logic [P_W-1:0]     p1_nxt, p2_nxt, p3_nxt;
  logic [B_W-1:0]     b_nxt, cmag_nxt;
  logic [COEFF_W-1:0] a_nxt;
  logic               cpos_nxt;

  always_comb begin
    p1_nxt = P_W'(cfg.coeff_one) * P_W'(s2_m1_r);
    p2_nxt = P_W'(cfg.coeff_two) * P_W'(s2_m2_r);
    p3_nxt = P_W'(cfg.coeff_three) * P_W'(s2_m3_r);
    if (cfg.prefix_profile) begin
      a_nxt    = cfg.coeff_one;
      b_nxt    = B_W'(cfg.coeff_two) + s2_c3p_r;
      cpos_nxt = s2_cp_r > B_W'(s2_t_r);
      cmag_nxt = cpos_nxt ? (s2_cp_r - B_W'(s2_t_r)) : (B_W'(s2_t_r) - s2_cp_r);
    end else begin
      a_nxt    = cfg.coeff_two;
      b_nxt    = B_W'(cfg.coeff_one);
      cpos_nxt = 1'b0;
      cmag_nxt = B_W'(s2_t_r);
    end
  end

  // stage 3 -> 4
  logic signed [SUM_W-1:0] t1, t2, t3, acc;
  logic [COEFF_W-1:0]      ptime_nxt;
  logic [COEFF_W-1:0]      bl, cl;
  logic [HI_W-1:0]         bh, ch;

  always_comb begin
    t1  = SUM_W'(s3_p1_r);
    t2  = SUM_W'(s3_p2_r);
    t3  = SUM_W'(s3_p3_r);
    acc = (s3_addc_r ? SUM_W'(cfg.coeff_constant) : SUM_W'(0)) + SUM_W'(s3_cpt_r)
        + (s3_n1_r ? -t1 : t1) + (s3_n2_r ? -t2 : t2) + (s3_n3_r ? -t3 : t3);
    if (s3_kind_r != KIND_PREDICT || acc[SUM_W-1])
      ptime_nxt = '0;
    else if (|acc[SUM_W-2:COEFF_W])
      ptime_nxt = TIME_MAX;
    else
      ptime_nxt = acc[COEFF_W-1:0];
    bl = s3_b_r[COEFF_W-1:0];
    bh = s3_b_r[B_W-1:COEFF_W];
    cl = s3_cmag_r[COEFF_W-1:0];
    ch = s3_cmag_r[B_W-1:COEFF_W];
  end

  // stage 4 -> 5
  logic [D_W-1:0] bsq_nxt, fac_nxt;

  always_comb begin
    bsq_nxt = D_W'(s4_bll_r) + (D_W'(s4_blh_r) << (COEFF_W + 1))
            + (D_W'(s4_bhh_r) << (2 * COEFF_W));
    fac_nxt = (D_W'(s4_acl_r) + (D_W'(s4_ach_r) << COEFF_W)) << 2;
  end

  // stage 5 -> root chain
  status_t st;

  always_comb begin
    if (s5_kind_r == KIND_PREDICT)
      st = ST_OK;
    else if (!cfg.prefill_mode)
      st = ST_NOT_PREFILL;
    else if (s5_a_r == '0)
      st = ST_ZERO_LEAD;
    else if (s5_cpos_r)
      st = (s5_fac_r <= s5_bsq_r) ? ST_NEG_ROOT : ST_NO_ROOT;
    else
      st = ST_OK;
    sq_o.tag.vld    = s5_vld_r;
    sq_o.tag.kind   = s5_kind_r;
    sq_o.tag.ptime  = s5_ptime_r;
    sq_o.tag.pre    = s5_pre_r;
    sq_o.tag.status = st;
    sq_o.d          = s5_bsq_r + s5_fac_r;
    sq_o.rem        = '0;
    sq_o.root       = '0;
    sq_o.b          = s5_b_r;
    sq_o.a2         = {s5_a_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r  <= in_kind;
      s1_len_r   <= in_token_length;
      s1_pre_r   <= in_prefix_tokens;
      s1_addc_r  <= in_add_constant;
      s1_t_r     <= in_time_budget;

      s2_kind_r  <= s1_kind_r;
      s2_addc_r  <= s1_addc_r;
      s2_pre_r   <= s1_pre_r;
      s2_t_r     <= s1_t_r;
      s2_m1_r    <= m1_nxt;
      s2_m2_r    <= m2_nxt;
      s2_m3_r    <= m3_nxt;
      s2_n1_r    <= n1_nxt;
      s2_n2_r    <= n2_nxt;
      s2_n3_r    <= n3_nxt;
      s2_usecp_r <= usecp_nxt;
      s2_cp_r    <= cp_nxt;
      s2_c3p_r   <= c3p_nxt;

      s3_kind_r  <= s2_kind_r;
      s3_addc_r  <= s2_addc_r;
      s3_pre_r   <= s2_pre_r;
      s3_p1_r    <= p1_nxt;
      s3_p2_r    <= p2_nxt;
      s3_p3_r    <= p3_nxt;
      s3_n1_r    <= s2_n1_r;
      s3_n2_r    <= s2_n2_r;
      s3_n3_r    <= s2_n3_r;
      s3_cpt_r   <= s2_usecp_r ? s2_cp_r : '0;
      s3_b_r     <= b_nxt;
      s3_a_r     <= a_nxt;
      s3_cpos_r  <= cpos_nxt;
      s3_cmag_r  <= cmag_nxt;

      s4_kind_r  <= s3_kind_r;
      s4_pre_r   <= s3_pre_r;
      s4_ptime_r <= ptime_nxt;
      s4_b_r     <= s3_b_r;
      s4_a_r     <= s3_a_r;
      s4_cpos_r  <= s3_cpos_r;
      s4_bll_r   <= (2*COEFF_W)'(bl) * (2*COEFF_W)'(bl);
      s4_blh_r   <= (COEFF_W+HI_W)'(bl) * (COEFF_W+HI_W)'(bh);
      s4_bhh_r   <= (2*HI_W)'(bh) * (2*HI_W)'(bh);
      s4_acl_r   <= (2*COEFF_W)'(s3_a_r) * (2*COEFF_W)'(cl);
      s4_ach_r   <= (COEFF_W+HI_W)'(s3_a_r) * (COEFF_W+HI_W)'(ch);

      s5_kind_r  <= s4_kind_r;
      s5_pre_r   <= s4_pre_r;
      s5_ptime_r <= s4_ptime_r;
      s5_b_r     <= s4_b_r;
      s5_a_r     <= s4_a_r;
      s5_cpos_r  <= s4_cpos_r;
      s5_bsq_r   <= bsq_nxt;
      s5_fac_r   <= fac_nxt;
    end
  end

endmodule

FILE: design/lcme_sqrt_cell.sv
// ----------------------------------------------------------------------------
// lcme_sqrt_cell: one digit of the integer square root
// Brings in the next two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module lcme_sqrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  lcme_pkg::sq_t sq_i,
  output lcme_pkg::sq_t sq_o
);
  import lcme_pkg::*;

  sq_t            sq_r, sq_nxt;
  logic [R_W+2:0] trial_in, trial;
  logic           ge;

  always_comb begin
    trial_in = {sq_i.rem, sq_i.d[D_W-1 -: 2]};
    trial    = {1'b0, sq_i.root, 2'b01};
    ge       = trial_in >= trial;
    sq_nxt       = sq_i;
    sq_nxt.d     = sq_i.d << 2;
    sq_nxt.rem   = ge ? (R_W+1)'(trial_in - trial) : trial_in[R_W:0];
    sq_nxt.root  = {sq_i.root[R_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r <= '0;
    end else if (adv) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq_o = sq_r;

endmodule

FILE: design/lcme_div_cell.sv
// ----------------------------------------------------------------------------
// lcme_div_cell: one quotient bit of the restoring divider
// Shifts in the next dividend bit and subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module lcme_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  lcme_pkg::dv_t dv_i,
  output lcme_pkg::dv_t dv_o
);
  import lcme_pkg::*;

  dv_t           dv_r, dv_nxt;
  logic [A2_W:0] part, diff;
  logic          ge;

  always_comb begin
    part = {dv_i.rem, dv_i.num[R_W-1]};
    ge   = part >= {1'b0, dv_i.dv};
    diff = part - {1'b0, dv_i.dv};
    dv_nxt     = dv_i;
    dv_nxt.num = dv_i.num << 1;
    dv_nxt.rem = ge ? diff[A2_W-1:0] : part[A2_W-1:0];
    dv_nxt.q   = {dv_i.q[R_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (adv) begin
      dv_r <= dv_nxt;
    end
  end

  assign dv_o = dv_r;

endmodule

FILE: design/lcme_out.sv
// ----------------------------------------------------------------------------
// lcme_out: token limit, result assembly and output skid buffer
// Two-entry buffer keeps the chain moving while a result waits.
// ----------------------------------------------------------------------------
module lcme_out (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lcme_pkg::dv_t                   dv_i,
  output logic                            adv,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lcme_pkg::COEFF_W-1:0]    out_predicted_time,
  output logic [lcme_pkg::LENGTH_BITS-1:0] out_token_limit,
  output logic [2:0]                      out_status
);
  import lcme_pkg::*;

  result_t        ent0_r, ent1_r, res;
  logic [1:0]     count_r;
  logic [R_W:0]   sum;
  logic           push, pop, wr_idx;

  always_comb begin
    sum = (R_W+1)'(dv_i.q) + (R_W+1)'(dv_i.tag.pre);
    res.ptime  = dv_i.tag.ptime;
    res.status = dv_i.tag.status;
    if (dv_i.tag.kind == KIND_PREDICT)
      res.limit = '0;
    else if (dv_i.tag.status != ST_OK)
      res.limit = dv_i.tag.pre;
    else if (sum > (R_W+1)'(LEN_MAX))
      res.limit = LEN_MAX;
    else
      res.limit = sum[LENGTH_BITS-1:0];
  end

  // hold the chain on the buffer count and the chain-end valid alone, so out_ready never reaches in_ready
  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign adv       = !dv_i.tag.vld || (count_r != 2'd2);
  assign push      = dv_i.tag.vld && adv;
  assign wr_idx    = ((count_r - {1'b0, pop}) != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !wr_idx) begin
      ent0_r <= res;
    end else if (pop) begin
      ent0_r <= ent1_r;
    end
    if (push && wr_idx) begin
      ent1_r <= res;
    end
  end

  assign out_predicted_time = ent0_r.ptime;
  assign out_token_limit    = ent0_r.limit;
  assign out_status         = ent0_r.status;

endmodule

FILE: design/latency_cost_model_evaluator.sv
// ----------------------------------------------------------------------------
// latency_cost_model_evaluator: polynomial run-time model and budget solver
// Predicts model time or solves the token limit for a time budget.
//
//   channel  signals                          role
//   in       in_valid / in_ready + fields     request transaction
//   out      out_valid / out_ready + fields   result transaction
//   cfg      cfg_we, cfg_index, cfg_wdata     register write
//
// One transaction enters per cycle while the chain is not frozen; every result
// passes five front stages, one square-root cell and one divider cell per root
// bit, then the output buffer.
// Synchronous active-low reset clears the configuration, the chain cells and all stage valids.
// A full output buffer with a result at the chain end freezes the whole chain;
// in_ready follows the buffer count and the chain-end valid, not out_ready.
// ----------------------------------------------------------------------------
module latency_cost_model_evaluator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [lcme_pkg::LENGTH_BITS-1:0]  in_token_length,
  input  logic [lcme_pkg::LENGTH_BITS-1:0]  in_prefix_tokens,
  input  logic                              in_add_constant,
  input  logic [lcme_pkg::COEFF_W-1:0]      in_time_budget,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lcme_pkg::COEFF_W-1:0]      out_predicted_time,
  output logic [lcme_pkg::LENGTH_BITS-1:0]  out_token_limit,
  output logic [2:0]                        out_status,
  input  logic                              cfg_we,
  input  logic [lcme_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcme_pkg::COEFF_W-1:0]      cfg_wdata
);
  import lcme_pkg::*;

  cfg_t cfg_r;
  logic adv;
  sq_t  sq_w [0:R_W];
  dv_t  dv_w [0:R_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PREFILL_MODE:   cfg_r.prefill_mode   <= cfg_wdata[0];
        CFG_PREFIX_PROFILE: cfg_r.prefix_profile <= cfg_wdata[0];
        CFG_COEFF_CONSTANT: cfg_r.coeff_constant <= cfg_wdata;
        CFG_COEFF_ONE:      cfg_r.coeff_one      <= cfg_wdata;
        CFG_COEFF_TWO:      cfg_r.coeff_two      <= cfg_wdata;
        CFG_COEFF_THREE:    cfg_r.coeff_three    <= cfg_wdata;
        CFG_COEFF_FOUR:     cfg_r.coeff_four     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = adv;

  lcme_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .in_valid         (in_valid),
    .in_kind          (in_kind),
    .in_token_length  (in_token_length),
    .in_prefix_tokens (in_prefix_tokens),
    .in_add_constant  (in_add_constant),
    .in_time_budget   (in_time_budget),
    .cfg              (cfg_r),
    .sq_o             (sq_w[0])
  );

  for (genvar i = 0; i < R_W; i++) begin : g_sqrt
    lcme_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .sq_i  (sq_w[i]),
      .sq_o  (sq_w[i+1])
    );
  end

  // hand the root over to the divider: (s - b) / 2a
  assign dv_w[0].tag = sq_w[R_W].tag;
  assign dv_w[0].num = sq_w[R_W].root - R_W'(sq_w[R_W].b);
  assign dv_w[0].rem = '0;
  assign dv_w[0].q   = '0;
  assign dv_w[0].dv  = sq_w[R_W].a2;

  for (genvar i = 0; i < R_W; i++) begin : g_div
    lcme_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .dv_i  (dv_w[i]),
      .dv_o  (dv_w[i+1])
    );
  end

  lcme_out u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .dv_i               (dv_w[R_W]),
    .adv                (adv),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_predicted_time (out_predicted_time),
    .out_token_limit    (out_token_limit),
    .out_status         (out_status)
  );

endmodule
